[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/cwms_pkg.sv]
// Shared constants and types for the channel window mean and deviation block.
package cwms_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int MAX_REPORT       = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CHAN_W     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int SQUARE_W   = 31;
    localparam int TICK_W     = 10;
    localparam int ACT_W      = 5;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 48;
    localparam int SUMSQ_W    = 64;
    localparam int DEN_W      = 20;
    localparam int VAR_W      = 58;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 8'd1;

    localparam logic [TICK_W-1:0] WINDOW_RESET = 10'd60;
    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 5'd16;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic                       in_range;
        logic signed [SAMPLE_W-1:0] sample;
        logic [SQUARE_W-1:0]        square;
        logic                       tick_end;
    } item_t;

endpackage

[rtl/core/cwms_front.sv]
// Front end: accepts samples, classifies the channel, squares the sample and queues it.
module cwms_front #(
    parameter int NUM_CHANNELS = cwms_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [cwms_pkg::CHAN_W-1:0]          s_channel,
    input  logic signed [cwms_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_tick_end,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output cwms_pkg::item_t                      q_item
);
    import cwms_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t                   q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    push;
    logic                    pop;
    logic signed [2*SAMPLE_W-1:0] product;
    item_t                   new_item;

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign q_item  = q_mem[rd_ptr_reg];

    assign product = s_sample * s_sample;

    always_comb begin
        new_item.channel  = s_channel;
        new_item.in_range = (int'(s_channel) < NUM_CHANNELS);
        new_item.sample   = s_sample;
        new_item.square   = product[SQUARE_W-1:0];
        new_item.tick_end = s_tick_end;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

[rtl/core/cwms_divider.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
module cwms_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_diff;
    logic             fits;

    assign trial      = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign fits       = (trial >= {1'b0, den_reg});
    assign busy       = busy_reg;
    assign quotient   = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
            cnt_reg  <= CNT_W'(NUM_W);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            cnt_reg <= CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/cwms_isqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
module cwms_isqrt #(
    parameter int W = 58
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [W-1:0]       radicand,
    output logic               busy,
    output logic [W/2-1:0]     root
);
    localparam int STEPS = W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [W-1:0]     x_reg;
    logic [W-1:0]     root_reg;
    logic [W-1:0]     bit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [W-1:0]     trial;
    logic             fits;

    assign trial = root_reg + bit_reg;
    assign fits  = (x_reg >= trial);
    assign busy  = busy_reg;
    assign root  = root_reg[W/2-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            x_reg    <= radicand;
            root_reg <= '0;
            bit_reg  <= W'(1) << (W - 2);
            cnt_reg  <= CNT_W'(STEPS);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                x_reg    <= x_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            cnt_reg <= CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/cwms_back.sv]
// Back end: accumulates queued samples and runs the per-channel window report.
module cwms_back #(
    parameter int NUM_CHANNELS = cwms_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  cwms_pkg::item_t                      q_item,
    input  logic [cwms_pkg::TICK_W-1:0]          window_ticks,
    input  logic [cwms_pkg::ACT_W-1:0]           report_count,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [cwms_pkg::CHAN_W-1:0]          m_out_channel,
    output logic signed [cwms_pkg::SAMPLE_W-1:0] m_mean,
    output logic [cwms_pkg::SAMPLE_W-1:0]        m_std_dev,
    output logic                                 m_last
);
    import cwms_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_RD, S_MUL, S_SQ, S_DIV, S_DWAIT, S_SQWAIT, S_OUT
    } state_t;

    state_t              state_reg;
    item_t               cur_reg;
    logic [TICK_W-1:0]   tc_reg;
    logic [TICK_W-1:0]   n_reg;
    logic                ngt1_reg;
    logic [ACT_W-1:0]    k_reg;
    logic [ACT_W-1:0]    rpt_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [SUM_W-1:0]    abs_reg;
    logic                neg_reg;
    logic [SUMSQ_W-1:0]  sumsq_reg;
    logic [VAR_W-1:0]    scaled_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic                vld_rd_reg;
    logic [NUM_CHANNELS-1:0] vld_reg;
    logic [SUM_W-1:0]    sum_rd_reg;
    logic [SQ_W-1:0]     sq_rd_reg;
    logic [SUM_W-1:0]    sum_mem [NUM_CHANNELS];
    logic [SQ_W-1:0]     sq_mem  [NUM_CHANNELS];

    logic                m_valid_reg;
    logic [CHAN_W-1:0]   m_chan_reg;
    logic [SAMPLE_W-1:0] m_mean_reg;
    logic [SAMPLE_W-1:0] m_sd_reg;
    logic                m_last_reg;

    logic [CH_W-1:0]     rd_addr;
    logic [CH_W-1:0]     wr_addr;
    logic                mem_we;
    logic                win_drop;
    logic [SUM_W-1:0]    sum_val;
    logic [SQ_W-1:0]     sq_val;
    logic [SUM_W-1:0]    abs_c;
    logic [TICK_W-1:0]   tc_inc;
    logic [TICK_W-1:0]   n_win;
    logic [VAR_W-1:0]    diff_c;
    logic                div_start;
    logic                sqrt_start;
    logic                vdiv_busy;
    logic                mdiv_busy;
    logic                sqrt_busy;
    logic [VAR_W-1:0]    var_q;
    logic [SUM_W-1:0]    mean_q;
    logic [VAR_W/2-1:0]  root;
    logic [SAMPLE_W-1:0] mean_sat;
    logic [SAMPLE_W-1:0] sd_sat;
    logic                out_free;

    assign q_ready = (state_reg == S_IDLE);
    assign rd_addr = (state_reg == S_IDLE) ? CH_W'(q_item.channel) : CH_W'(k_reg);
    assign wr_addr = CH_W'(cur_reg.channel);
    assign mem_we  = (state_reg == S_ACC) && cur_reg.in_range;

    // Entries whose valid bit is clear read as zero; that is how a window clears.
    assign sum_val = vld_rd_reg ? sum_rd_reg : '0;
    assign sq_val  = vld_rd_reg ? sq_rd_reg  : '0;
    assign abs_c   = sum_val[SUM_W-1] ? SUM_W'(-sum_val) : sum_val;

    assign tc_inc = TICK_W'(tc_reg + 1'b1);
    assign n_win  = (tc_inc == '0) ? TICK_W'(1) : tc_inc;

    // A window that ends with no channel to report is cleared right away.
    assign win_drop = cur_reg.tick_end && (tc_inc >= window_ticks) && (report_count == '0);

    assign diff_c = (ngt1_reg && ({{(SUMSQ_W-VAR_W){1'b0}}, scaled_reg} > sumsq_reg))
                    ? VAR_W'(scaled_reg - sumsq_reg[VAR_W-1:0]) : '0;

    assign div_start  = (state_reg == S_DIV);
    assign sqrt_start = (state_reg == S_DWAIT) && !vdiv_busy && !mdiv_busy;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        if (neg_reg) begin
            mean_sat = (mean_q > SUM_W'(32768)) ? 16'h8000 : SAMPLE_W'(-mean_q);
        end else begin
            mean_sat = (mean_q > SUM_W'(32767)) ? 16'h7FFF : mean_q[SAMPLE_W-1:0];
        end
        sd_sat = (root > (VAR_W/2)'(16'hFFFF)) ? 16'hFFFF : root[SAMPLE_W-1:0];
    end

    cwms_divider #(.NUM_W(VAR_W), .DEN_W(DEN_W)) u_var_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff_c),
        .divisor  (den_reg),
        .busy     (vdiv_busy),
        .quotient (var_q)
    );

    cwms_divider #(.NUM_W(SUM_W), .DEN_W(TICK_W)) u_mean_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (abs_reg),
        .divisor  (n_reg),
        .busy     (mdiv_busy),
        .quotient (mean_q)
    );

    cwms_isqrt #(.W(VAR_W)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (ngt1_reg ? var_q : '0),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        sum_rd_reg <= sum_mem[rd_addr];
        sq_rd_reg  <= sq_mem[rd_addr];
        if (mem_we) begin
            sum_mem[wr_addr] <= sum_val + SUM_W'(cur_reg.sample);
            sq_mem[wr_addr]  <= sq_val + SQ_W'(cur_reg.square);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tc_reg      <= '0;
            vld_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            vld_rd_reg <= vld_reg[rd_addr];
            if (m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cur_reg   <= q_item;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (mem_we && !win_drop) begin
                        vld_reg[wr_addr] <= 1'b1;
                    end
                    state_reg <= S_IDLE;
                    if (cur_reg.tick_end) begin
                        if (tc_inc >= window_ticks) begin
                            if (report_count == '0) begin
                                vld_reg <= '0;
                                tc_reg  <= '0;
                            end else begin
                                n_reg     <= n_win;
                                ngt1_reg  <= (n_win > TICK_W'(1));
                                rpt_reg   <= report_count;
                                k_reg     <= '0;
                                state_reg <= S_RD;
                            end
                        end else begin
                            tc_reg <= tc_inc;
                        end
                    end
                end
                S_RD: begin
                    den_reg   <= DEN_W'(n_reg) * DEN_W'(n_reg - 1'b1);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    abs_reg    <= abs_c;
                    neg_reg    <= sum_val[SUM_W-1];
                    scaled_reg <= VAR_W'(n_reg) * VAR_W'(sq_val);
                    state_reg  <= S_SQ;
                end
                S_SQ: begin
                    sumsq_reg <= SUMSQ_W'(abs_reg) * SUMSQ_W'(abs_reg);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (!vdiv_busy && !mdiv_busy) begin
                        mean_reg  <= mean_sat;
                        state_reg <= S_SQWAIT;
                    end
                end
                S_SQWAIT: begin
                    if (!sqrt_busy) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_chan_reg  <= k_reg[CHAN_W-1:0];
                        m_mean_reg  <= mean_reg;
                        m_sd_reg    <= sd_sat;
                        m_last_reg  <= (ACT_W'(k_reg + 1'b1) == rpt_reg);
                        if (ACT_W'(k_reg + 1'b1) == rpt_reg) begin
                            vld_reg   <= '0;
                            tc_reg    <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= ACT_W'(k_reg + 1'b1);
                            state_reg <= S_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_chan_reg;
    assign m_mean        = m_mean_reg;
    assign m_std_dev     = m_sd_reg;
    assign m_last        = m_last_reg;

endmodule

[rtl/core/channel_window_mean_stddev_top.sv]
// Top level of the channel window mean and standard deviation block.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_valid / s_ready     s_channel, s_sample, s_tick_end
//   m_        out        m_valid / m_ready     m_out_channel, m_mean, m_std_dev, m_last
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample that does not end a window passes through S_IDLE and S_ACC in the back end;
// a two-entry queue lets the front keep accepting while the back is busy.
// Each reported channel runs the 58-step variance division and the 29-step square root,
// one after the other, besides the S_RD, S_MUL, S_SQ, S_DIV and S_OUT states.
// Reset is synchronous and clears the stores at once through per-channel valid bits.
// A stalled result holds the report; accumulation resumes after the last result.
`include "assert_macros.svh"

module channel_window_mean_stddev_top #(
    parameter int NUM_CHANNELS = cwms_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [cwms_pkg::CHAN_W-1:0]            s_channel,
    input  logic signed [cwms_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic                                   s_tick_end,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [cwms_pkg::CHAN_W-1:0]            m_out_channel,
    output logic signed [cwms_pkg::SAMPLE_W-1:0]   m_mean,
    output logic [cwms_pkg::SAMPLE_W-1:0]          m_std_dev,
    output logic                                   m_last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cwms_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cwms_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import cwms_pkg::*;

    localparam int RPT_LIM = (NUM_CHANNELS < MAX_REPORT) ? NUM_CHANNELS : MAX_REPORT;

    logic [TICK_W-1:0] window_reg;
    logic [ACT_W-1:0]  active_reg;
    logic [ACT_W-1:0]  rpt_lim;
    logic [ACT_W-1:0]  rpt_last;
    logic              q_valid;
    logic              q_ready;
    item_t             q_item;

    assign cfg_ready = 1'b1;
    assign rpt_lim   = (active_reg > ACT_W'(RPT_LIM)) ? ACT_W'(RPT_LIM) : active_reg;
    assign rpt_last  = ACT_W'(rpt_lim - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            active_reg <= ACTIVE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_WINDOW_TICKS) begin
                window_reg <= cfg_data[TICK_W-1:0];
            end else if (cfg_index == REG_ACTIVE_CHANNELS) begin
                active_reg <= cfg_data[ACT_W-1:0];
            end
        end
    end

    cwms_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_channel  (s_channel),
        .s_sample   (s_sample),
        .s_tick_end (s_tick_end),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    cwms_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .window_ticks  (window_reg),
        .report_count  (rpt_lim),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_mean        (m_mean),
        .m_std_dev     (m_std_dev),
        .m_last        (m_last)
    );

    `CWMS_ASSERT_IMP(a_last_is_final, aclk, aresetn, (m_valid && m_last), (m_out_channel == 4'(rpt_last)))
    `CWMS_ASSERT_IMP(a_inner_in_report, aclk, aresetn, (m_valid && !m_last), ({1'b0, m_out_channel} < rpt_last))
    `CWMS_ASSERT_IMP(a_report_nonempty, aclk, aresetn, m_valid, (rpt_lim != 5'd0))

endmodule
